// ----- sv/aesctr_pkg.sv -----
// Package: AES-128 CTR types, S-box and round helpers.
`default_nettype none
package aesctr_pkg;

  localparam int unsigned QDEPTH = 2;

  typedef struct packed {
    logic [63:0] data_high;
    logic [63:0] data_low;
    logic [4:0]  byte_count;
    logic [127:0] ctr;
  } job_t;

  typedef enum logic [3:0] {
    REG_KEY_HIGH   = 4'd0,
    REG_KEY_LOW    = 4'd1,
    REG_NONCE_HIGH = 4'd2,
    REG_NONCE_LOW  = 4'd3
  } reg_idx_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[x];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of a 128-bit word sits in bits 127-8i downto 120-8i.
  function automatic logic [7:0] getb(input logic [127:0] w, input int i);
    return w[127 - 8*i -: 8];
  endfunction

endpackage
`default_nettype wire

// ----- sv/aesctr_if.sv -----
// Valid/ready channel interfaces for input and result transactions.
`default_nettype none
interface aesctr_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_high;
  logic [63:0] data_low;
  logic        start_message;
  logic [4:0]  byte_count;
  modport source (output valid, data_high, data_low, start_message, byte_count, input ready);
  modport sink   (input valid, data_high, data_low, start_message, byte_count, output ready);
endinterface

interface aesctr_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_high;
  logic [63:0] out_low;
  logic [4:0]  out_count;
  modport source (output valid, out_high, out_low, out_count, input ready);
  modport sink   (input valid, out_high, out_low, out_count, output ready);
endinterface
`default_nettype wire

// ----- sv/aes128_ctr_crypt_core.sv -----
// Top level: AES-128 CTR block cipher core.
// Usage: write key_high/key_low/nonce_high/nonce_low through cfg_we/cfg_index/
// cfg_data while idle. Send blocks on in_ch (valid/ready); a transaction with
// start_message set reloads the counter from the nonce first. Each block is
// XORed with AES-128(counter); bytes at or past byte_count come out zero.
// The counter advances by one after every full block (count 16 or more).
// The front end keeps the counter and a two-entry job queue; the back end
// runs one round per cycle in a shared round unit with on-the-fly key
// expansion, except that the last round waits while the result register is
// full: each job is loaded, then runs the ten rounds, and the result is
// registered in the last round; the next job is taken only after that.
// The result register holds on out_ch until taken; while it is full the last
// round waits, and the queue keeps accepting up to two further blocks.
// Reset (synchronous, active high) clears registers, counter and queue.
`default_nettype none
module aes128_ctr_crypt_core import aesctr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  aesctr_in_if.sink        in_ch,
  aesctr_out_if.source     out_ch
);
  logic [63:0] key_high, key_low, nonce_high, nonce_low;
  logic        job_valid, job_take;
  job_t        job;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0; key_low <= '0; nonce_high <= '0; nonce_low <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'({2'b00, cfg_index}))
        REG_KEY_HIGH:   key_high <= cfg_data;
        REG_KEY_LOW:    key_low <= cfg_data;
        REG_NONCE_HIGH: nonce_high <= cfg_data;
        REG_NONCE_LOW:  nonce_low <= cfg_data;
        default: ;
      endcase
    end
  end

  aesctr_front u_front (
    .clk, .rst, .in_ch, .nonce({nonce_high, nonce_low}),
    .job_valid, .job_take, .job
  );

  aesctr_back u_back (
    .clk, .rst, .key({key_high, key_low}),
    .job_valid, .job_take, .job, .out_ch
  );
endmodule
`default_nettype wire

// ----- sv/aesctr_front.sv -----
// Front end: counter tracking and job queue.
`default_nettype none
module aesctr_front import aesctr_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  aesctr_in_if.sink   in_ch,
  input  wire logic [127:0] nonce,
  output logic        job_valid,
  input  wire logic   job_take,
  output job_t        job
);
  logic [127:0] ctr;
  job_t         q [QDEPTH];
  logic         rd_ptr, wr_ptr;
  logic [1:0]   fill;
  logic [127:0] cur_ctr, inc_ctr;
  logic [127:0] ctr_le;
  logic         acc;

  assign in_ch.ready = (fill != 2'(QDEPTH));
  assign acc = in_ch.valid & in_ch.ready;
  assign cur_ctr = in_ch.start_message ? nonce : ctr;

  // byte 0 is least significant: reverse bytes, add one, reverse back
  always_comb begin
    for (int i = 0; i < 16; i++) ctr_le[8*i +: 8] = getb(cur_ctr, i);
    ctr_le = ctr_le + 128'd1;
    for (int i = 0; i < 16; i++) inc_ctr[127 - 8*i -: 8] = ctr_le[8*i +: 8];
  end

  assign job_valid = (fill != 2'd0);
  assign job = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctr <= '0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (acc) begin
        q[wr_ptr] <= '{data_high: in_ch.data_high, data_low: in_ch.data_low,
                       byte_count: in_ch.byte_count, ctr: cur_ctr};
        wr_ptr <= ~wr_ptr;
        ctr <= (in_ch.byte_count >= 5'd16) ? inc_ctr : cur_ctr;
      end
      if (job_take) rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(acc) - 2'(job_take);
    end
  end
endmodule
`default_nettype wire

// ----- sv/aesctr_back.sv -----
// Back end: iterative AES-128 round unit with on-the-fly key schedule.
`default_nettype none
module aesctr_back import aesctr_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic [127:0] key,
  input  wire logic   job_valid,
  output logic        job_take,
  input  job_t        job,
  aesctr_out_if.source out_ch
);
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  state_t       state;
  logic [3:0]   round;
  logic [127:0] s, rk, dat, rk_next, s_next;
  logic [7:0]   rc;
  logic [4:0]   cnt;
  logic [127:0] t, m, ks;
  logic         out_busy;
  logic         last_round;

  assign out_busy = out_ch.valid & ~out_ch.ready;
  assign job_take = (state == S_IDLE) & job_valid;
  assign last_round = (state == S_RUN) && (round == 4'd10);

  always_comb begin
    logic [7:0] a0, a1, a2, a3, al;
    rk_next[127:120] = getb(rk,0) ^ sbox(getb(rk,13)) ^ rc;
    rk_next[119:112] = getb(rk,1) ^ sbox(getb(rk,14));
    rk_next[111:104] = getb(rk,2) ^ sbox(getb(rk,15));
    rk_next[103:96]  = getb(rk,3) ^ sbox(getb(rk,12));
    for (int i = 4; i < 16; i++)
      rk_next[127 - 8*i -: 8] = getb(rk, i) ^ rk_next[127 - 8*(i-4) -: 8];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[127 - 8*(r + 4*c) -: 8] = sbox(getb(s, r + 4*((c + r) & 3)));
    for (int c = 0; c < 4; c++) begin
      a0 = getb(t, 4*c); a1 = getb(t, 4*c+1); a2 = getb(t, 4*c+2); a3 = getb(t, 4*c+3);
      al = a0 ^ a1 ^ a2 ^ a3;
      m[127 - 8*(4*c)   -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
      m[127 - 8*(4*c+1) -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
      m[127 - 8*(4*c+2) -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      m[127 - 8*(4*c+3) -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    s_next = ((round == 4'd10) ? t : m) ^ rk_next;
    ks = s_next ^ dat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_ch.valid <= 1'b0;
    end else begin
      // the last round reloads the result register itself
      if (out_ch.valid & out_ch.ready & ~last_round) out_ch.valid <= 1'b0;
      case (state)
        S_IDLE: if (job_valid) begin
          s <= job.ctr ^ key;
          rk <= key;
          rc <= 8'h01;
          round <= 4'd1;
          dat <= {job.data_high, job.data_low};
          cnt <= job.byte_count;
          state <= S_RUN;
        end
        S_RUN: if (!(round == 4'd10 && out_busy)) begin
          s <= s_next;
          rk <= rk_next;
          rc <= xtime(rc);
          round <= round + 4'd1;
          if (round == 4'd10) begin
            for (int i = 0; i < 16; i++) begin
              if (i < 32'(cnt)) begin
                if (i < 8) out_ch.out_high[63 - 8*i -: 8] <= ks[127 - 8*i -: 8];
                else out_ch.out_low[63 - 8*(i-8) -: 8] <= ks[127 - 8*i -: 8];
              end else begin
                if (i < 8) out_ch.out_high[63 - 8*i -: 8] <= 8'h00;
                else out_ch.out_low[63 - 8*(i-8) -: 8] <= 8'h00;
              end
            end
            out_ch.out_count <= cnt;
            out_ch.valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
